@@ rtl/lora_airtime_from_preset_unit_assert.svh @@
// ----------------------------------------------------------------------------
// lora airtime assertion macros
// shared property forms for the airtime unit checkers
// ----------------------------------------------------------------------------
`ifndef LORA_AIRTIME_FROM_PRESET_UNIT_ASSERT_SVH
`define LORA_AIRTIME_FROM_PRESET_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LAT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lat checker: property failed");

// next-cycle implication, disabled while reset is low
`define LAT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lat checker: property failed");

`endif

@@ rtl/lat_pkg.sv @@
// ----------------------------------------------------------------------------
// lat_pkg
// preset table, constants and shared types of the airtime unit
// ----------------------------------------------------------------------------
package lat_pkg;

  // preset codes
  localparam logic [3:0] PRESET_LONG_SLOW      = 4'd0;
  localparam logic [3:0] PRESET_LONG_FAST      = 4'd1;
  localparam logic [3:0] PRESET_LONG_MODERATE  = 4'd2;
  localparam logic [3:0] PRESET_VERY_LONG_SLOW = 4'd3;
  localparam logic [3:0] PRESET_MEDIUM_SLOW    = 4'd4;
  localparam logic [3:0] PRESET_MEDIUM_FAST    = 4'd5;
  localparam logic [3:0] PRESET_SHORT_SLOW     = 4'd6;
  localparam logic [3:0] PRESET_SHORT_FAST     = 4'd7;
  localparam logic [3:0] PRESET_SHORT_TURBO    = 4'd8;

  // ceil(2^16 / d) for the symbol divisor d = sf - 2*de
  localparam logic [13:0] RECIP_D10 = 14'd6554;
  localparam logic [13:0] RECIP_D9  = 14'd7282;
  localparam logic [13:0] RECIP_D8  = 14'd8192;
  localparam logic [13:0] RECIP_D7  = 14'd9363;
  localparam int          RECIP_D_SHIFT = 16;

  // ceil(2^32 / 125), exact for dividends below 2^22
  localparam logic [25:0] RECIP_125 = 26'd34359739;
  localparam int          RECIP_125_SHIFT = 32;

  // preamble plus header in quarter symbols: 4 * (8 + 4.25 + 8)
  localparam logic [11:0] FIXED_QSYMS = 12'd81;

  // per-preset modem settings
  typedef struct packed {
    logic [3:0]  sf;      // spreading factor
    logic [3:0]  dsym;    // sf - 2*de
    logic [13:0] recip;   // reciprocal of dsym
    logic        cr8;     // coding rate 4/8, else 4/5
    logic [3:0]  shamt;   // sf - log2(4*bw_khz/125)
  } lat_mode_t;

  // scaled quarter-symbol count handed from the symbol stages to the scaler
  typedef struct packed {
    logic [21:0] scaled;
  } lat_sym_t;

  function automatic lat_mode_t lat_lookup(input logic [3:0] preset);
    lat_mode_t m;
    unique case (preset)
      PRESET_LONG_SLOW, PRESET_VERY_LONG_SLOW:
        m = '{sf: 4'd12, dsym: 4'd10, recip: RECIP_D10, cr8: 1'b1, shamt: 4'd10};
      PRESET_LONG_MODERATE:
        m = '{sf: 4'd11, dsym: 4'd9, recip: RECIP_D9, cr8: 1'b0, shamt: 4'd9};
      PRESET_MEDIUM_SLOW:
        m = '{sf: 4'd10, dsym: 4'd10, recip: RECIP_D10, cr8: 1'b0, shamt: 4'd7};
      PRESET_MEDIUM_FAST:
        m = '{sf: 4'd9, dsym: 4'd9, recip: RECIP_D9, cr8: 1'b0, shamt: 4'd6};
      PRESET_SHORT_SLOW:
        m = '{sf: 4'd8, dsym: 4'd8, recip: RECIP_D8, cr8: 1'b0, shamt: 4'd5};
      PRESET_SHORT_FAST:
        m = '{sf: 4'd7, dsym: 4'd7, recip: RECIP_D7, cr8: 1'b0, shamt: 4'd4};
      PRESET_SHORT_TURBO:
        m = '{sf: 4'd7, dsym: 4'd7, recip: RECIP_D7, cr8: 1'b0, shamt: 4'd3};
      // long_fast and every unknown code
      default:
        m = '{sf: 4'd11, dsym: 4'd9, recip: RECIP_D9, cr8: 1'b1, shamt: 4'd9};
    endcase
    return m;
  endfunction

endpackage

@@ rtl/lat_symbols.sv @@
// ----------------------------------------------------------------------------
// lat_symbols
// three-stage pipe: preset lookup, ceiling divide, scaled symbol count
// ----------------------------------------------------------------------------
module lat_symbols (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [3:0]       in_preset,
  input  logic [7:0]       in_payload_bytes,
  output logic             out_valid,
  input  logic             out_ready,
  output lat_pkg::lat_sym_t out_sym
);
  import lat_pkg::*;

  lat_mode_t   mode_a;
  logic [9:0]  sum_a;
  logic [9:0]  x_a;
  logic [23:0] mul_b;
  logic [6:0]  c_c;
  logic [11:0] cw_c;
  logic [11:0] qsym_c;
  logic [21:0] scaled_c;

  logic        v_a_r, v_b_r, v_c_r;
  logic        rdy_a, rdy_b, rdy_c;

  logic [9:0]  x_a_r;
  logic [13:0] recip_a_r;
  logic        cr8_a_r, cr8_b_r;
  logic [3:0]  shamt_a_r, shamt_b_r;
  logic [22:0] prod_b_r;
  logic [21:0] scaled_c_r;

  // ready chain, a stage moves when it is empty or its successor moves
  assign rdy_c    = !v_c_r || out_ready;
  assign rdy_b    = !v_b_r || rdy_c;
  assign rdy_a    = !v_a_r || rdy_b;
  assign in_ready = rdy_a;

  // stage a: lookup and ceiling dividend (numerator already divided by 4)
  always_comb begin
    mode_a = lat_lookup(in_preset);
    sum_a  = {1'b0, in_payload_bytes, 1'b0} + 10'd11;
    if (sum_a > {6'd0, mode_a.sf}) begin
      x_a = sum_a - {6'd0, mode_a.sf} + {6'd0, mode_a.dsym} - 10'd1;
    end else begin
      x_a = 10'd0;
    end
  end

  // stage b: divide by the symbol divisor via reciprocal
  assign mul_b = {14'd0, x_a_r} * {10'd0, recip_a_r};

  // stage c: quarter symbols = 81 + 4*c*cr, then scale by 2^shamt
  always_comb begin
    c_c = prod_b_r[RECIP_D_SHIFT +: 7];
    if (cr8_b_r) begin
      cw_c = {c_c, 5'd0};
    end else begin
      cw_c = {1'b0, c_c, 4'd0} + {3'd0, c_c, 2'd0};
    end
    qsym_c   = FIXED_QSYMS + cw_c;
    scaled_c = {10'd0, qsym_c} << shamt_b_r;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
    end else begin
      if (rdy_a) v_a_r <= in_valid;
      if (rdy_b) v_b_r <= v_a_r;
      if (rdy_c) v_c_r <= v_b_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      x_a_r     <= x_a;
      recip_a_r <= mode_a.recip;
      cr8_a_r   <= mode_a.cr8;
      shamt_a_r <= mode_a.shamt;
    end
    if (rdy_b && v_a_r) begin
      prod_b_r  <= mul_b[22:0];
      cr8_b_r   <= cr8_a_r;
      shamt_b_r <= shamt_a_r;
    end
    if (rdy_c && v_b_r) begin
      scaled_c_r <= scaled_c;
    end
  end

  assign out_valid      = v_c_r;
  assign out_sym.scaled = scaled_c_r;

endmodule

@@ rtl/lat_scale.sv @@
// ----------------------------------------------------------------------------
// lat_scale
// output stage: divides the scaled symbol count by 125 into milliseconds
// ----------------------------------------------------------------------------
module lat_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lat_pkg::lat_sym_t in_sym,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [13:0]       out_airtime_ms
);
  import lat_pkg::*;

  logic [47:0] mul_d;
  logic        v_d_r;
  logic [13:0] ms_d_r;

  assign in_ready = !v_d_r || out_ready;

  // floor(scaled / 125) by reciprocal multiply
  assign mul_d = {26'd0, in_sym.scaled} * {22'd0, RECIP_125};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d_r <= 1'b0;
    end else if (in_ready) begin
      v_d_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ms_d_r <= mul_d[RECIP_125_SHIFT +: 14];
    end
  end

  assign out_valid      = v_d_r;
  assign out_airtime_ms = ms_d_r;

endmodule

@@ rtl/lora_airtime_from_preset_unit.sv @@
// ----------------------------------------------------------------------------
// lora_airtime_from_preset_unit
// packet time on air in milliseconds from a modem preset and payload length
// ----------------------------------------------------------------------------
// Takes one query per cycle while the result side keeps ready high and returns
// the time on air through four register stages (preset lookup, reciprocal
// divide by the symbol divisor, symbol count and scaling, reciprocal divide by
// 125). Stages advance independently, so a stalled result does not block new
// queries while there is room further up the pipe. Unknown preset codes are
// treated as long-fast.
module lora_airtime_from_preset_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_preset,
  input  logic [7:0]  in_payload_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_airtime_ms
);
  import lat_pkg::*;

  logic     sym_valid;
  logic     sym_ready;
  lat_sym_t sym;

  // symbol count stages
  lat_symbols u_lat_symbols (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_preset        (in_preset),
    .in_payload_bytes (in_payload_bytes),
    .out_valid        (sym_valid),
    .out_ready        (sym_ready),
    .out_sym          (sym)
  );

  // millisecond scaling and output register
  lat_scale u_lat_scale (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (sym_valid),
    .in_ready       (sym_ready),
    .in_sym         (sym),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_airtime_ms (out_airtime_ms)
  );

endmodule

@@ rtl/lat_checker.sv @@
// ----------------------------------------------------------------------------
// lat_checker
// port-level checks of the airtime unit, bound to the top level
// ----------------------------------------------------------------------------
`include "lora_airtime_from_preset_unit_assert.svh"

module lat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [13:0] out_airtime_ms
);

  // a pending result stays until its transaction
  `LAT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // longest packet is 14032 ms, so no result exceeds 14033
  `LAT_ASSERT_IMP(a_out_range, clk, rst_n, out_valid, out_airtime_ms <= 14'd14033)

  // reset empties the pipe
  `LAT_ASSERT_NXT(a_reset_empty, clk, 1'b1, !rst_n, !out_valid)

  // with the result side always ready, a query shows up after four stages
  `LAT_ASSERT_NXT(a_latency, clk, rst_n, (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready, out_valid)

endmodule

bind lora_airtime_from_preset_unit lat_checker u_lat_checker (.*);

@@ tb/sv/tb_lora_airtime_from_preset_unit.sv @@
// ----------------------------------------------------------------------------
// tb_lora_airtime_from_preset_unit
// self-checking bench for the packet airtime unit: every query transaction is
// predicted in the bench, and each result transaction is compared in order.
// The input and result sides idle at random in two of the three phases.
// ----------------------------------------------------------------------------
module tb_lora_airtime_from_preset_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lat_pkg::*;

  localparam int RANDOM_QUERIES = 400;
  localparam int STALL_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int MAX_PRINTS     = 20;

  // expected airtimes and the checks against them
  class airtime_board;
    logic [13:0] expected_airtime_q[$];
    int          queries;
    int          results;
    int          errors;
    int          zero_ceiling_hits;

    // time on air in ms for one preset and payload length
    function logic [13:0] calc_airtime_ms(logic [3:0] preset, logic [7:0] payload);
      int unsigned     sf, bw_khz, cr, de, pos, neg, den, csyms;
      longint unsigned qsyms, ms;
      case (preset)
        PRESET_LONG_SLOW, PRESET_VERY_LONG_SLOW: begin
          sf = 12; bw_khz = 125; cr = 8;
        end
        PRESET_LONG_MODERATE: begin
          sf = 11; bw_khz = 125; cr = 5;
        end
        PRESET_MEDIUM_SLOW: begin
          sf = 10; bw_khz = 250; cr = 5;
        end
        PRESET_MEDIUM_FAST: begin
          sf = 9; bw_khz = 250; cr = 5;
        end
        PRESET_SHORT_SLOW: begin
          sf = 8; bw_khz = 250; cr = 5;
        end
        PRESET_SHORT_FAST: begin
          sf = 7; bw_khz = 250; cr = 5;
        end
        PRESET_SHORT_TURBO: begin
          sf = 7; bw_khz = 500; cr = 5;
        end
        // long-fast and all unknown codes
        default: begin
          sf = 11; bw_khz = 125; cr = 8;
        end
      endcase
      de  = (sf >= 11) ? 1 : 0;
      pos = 8 * int'(payload) + 44;
      neg = 4 * sf;
      den = 4 * (sf - 2 * de);
      // payload symbol groups, clamped at zero for empty sf11 and sf12 packets
      csyms = 0;
      if (pos > neg) begin
        csyms = (pos - neg + den - 1) / den;
      end else begin
        zero_ceiling_hits++;
      end
      qsyms = 64'd81 + 64'd4 * csyms * cr;
      ms    = (qsyms << sf) / (64'd4 * bw_khz);
      return ms[13:0];
    endfunction

    function void note_query(logic [3:0] preset, logic [7:0] payload);
      queries++;
      expected_airtime_q.push_back(calc_airtime_ms(preset, payload));
    endfunction

    function int pending();
      return expected_airtime_q.size();
    endfunction

    task report_mismatch(string what, logic [13:0] got, logic [13:0] want);
      errors++;
      if (errors <= MAX_PRINTS) begin
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      end
    endtask

    task check_result(logic [13:0] airtime);
      logic [13:0] want;
      results++;
      if (expected_airtime_q.size() == 0) begin
        report_mismatch("unexpected result transaction", airtime, 14'd0);
      end else begin
        want = expected_airtime_q.pop_front();
        if (airtime !== want) begin
          report_mismatch("airtime_ms", airtime, want);
        end
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_preset = '0;
  logic [7:0]  in_payload_bytes = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [13:0] out_airtime_ms;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles  = 0;

  airtime_board board = new();

  lora_airtime_from_preset_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_preset        (in_preset),
    .in_payload_bytes (in_payload_bytes),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_airtime_ms   (out_airtime_ms)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // transaction monitor and stall counter
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        board.note_query(in_preset, in_payload_bytes);
      end
      if (out_valid && out_ready) begin
        board.check_result(out_airtime_ms);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // watchdog
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("stall: no transaction for %0d cycles", STALL_LIMIT);
    $display("tb_lora_airtime_from_preset_unit: FAIL");
    $finish;
  end

  // one query transaction, with random idle cycles ahead of it
  task automatic send_query(input logic [3:0] preset, input logic [7:0] payload);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_preset        <= preset;
    in_payload_bytes <= payload;
    do @(posedge clk); while (!in_ready);
  endtask

  // random queries, biased toward short payloads now and then
  task automatic send_random_queries(input int count);
    logic [7:0] payload;
    repeat (count) begin
      if ($urandom_range(3) == 0) begin
        payload = 8'($urandom_range(8));
      end else begin
        payload = 8'($urandom_range(255));
      end
      send_query(4'($urandom_range(15)), payload);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: sender idles lightly, receiver heavily
    send_idle_pct = 36;
    recv_idle_pct = 78;
    // every preset code with an empty payload, covers the zero clamp
    for (int p = 0; p < 16; p++) begin
      send_query(4'(p), 8'd0);
    end
    // longest payload on every distinct setting
    send_query(PRESET_LONG_SLOW, 8'd255);
    send_query(PRESET_LONG_FAST, 8'd255);
    send_query(PRESET_LONG_MODERATE, 8'd255);
    send_query(PRESET_MEDIUM_SLOW, 8'd255);
    send_query(PRESET_MEDIUM_FAST, 8'd255);
    send_query(PRESET_SHORT_SLOW, 8'd255);
    send_query(PRESET_SHORT_FAST, 8'd255);
    send_query(PRESET_SHORT_TURBO, 8'd255);
    // just past the clamp at sf12
    send_query(PRESET_VERY_LONG_SLOW, 8'd1);
    send_random_queries(RANDOM_QUERIES / 3);

    // phase two: roles swapped
    send_idle_pct = 78;
    recv_idle_pct = 36;
    send_random_queries(RANDOM_QUERIES / 3);

    // phase three: no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_queries(RANDOM_QUERIES - 2 * (RANDOM_QUERIES / 3));
    in_valid <= 1'b0;

    // drain the pipe
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d queries over all 16 preset codes, %0d results checked",
             board.queries, board.results);
    $display("zero-clamped symbol counts: %0d, mismatches: %0d",
             board.zero_ceiling_hits, board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("tb_lora_airtime_from_preset_unit: PASS");
    end else begin
      $display("tb_lora_airtime_from_preset_unit: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/lat_pkg.sv
rtl/lat_symbols.sv
rtl/lat_scale.sv
rtl/lora_airtime_from_preset_unit.sv
rtl/lat_checker.sv
tb/sv/tb_lora_airtime_from_preset_unit.sv
